FILE: rtl/assert_macros.svh
// assertion macros included by positional_insert_erase_list_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/piel_pkg.sv
`default_nettype none
package piel_pkg;

   localparam int POS_W  = 7;
   localparam int DATA_W = 32;
   localparam int SIZE_W = 7;
   localparam int CAPO_W = 8;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_GET    = 2'd2,
      OP_SET    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic              ins_shift;
      logic              era_shift;
      logic              write;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] data;
   } cell_cmd_type;

endpackage
`default_nettype wire

FILE: rtl/piel_cell.sv
`default_nettype none
module piel_cell import piel_pkg::*; #(
   parameter int IDX_W = 6,
   parameter int INDEX = 0
) (
   input  wire logic              clock,
   input  wire cell_cmd_type      cmd,
   input  wire logic [DATA_W-1:0] left_q,
   input  wire logic [DATA_W-1:0] right_q,
   output logic      [DATA_W-1:0] entry_q,
   output logic                   hit
);

   localparam int CW = (IDX_W > POS_W) ? IDX_W : POS_W;
   localparam logic [CW-1:0] ME = CW'(INDEX);

   logic [CW-1:0]     pos_x;
   logic              at_pos;
   logic              above_pos;
   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;

   assign pos_x     = CW'(cmd.position);
   assign at_pos    = (pos_x == ME);
   assign above_pos = (pos_x < ME);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins_shift && above_pos) begin
         entry_in = left_q;
      end else if (cmd.era_shift && (at_pos || above_pos)) begin
         entry_in = right_q;
      end else if (cmd.write && at_pos) begin
         entry_in = cmd.data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;
   assign hit     = at_pos;

endmodule
`default_nettype wire

FILE: rtl/piel_row.sv
`default_nettype none
module piel_row import piel_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  wire logic              clock,
   input  wire cell_cmd_type      cmd,
   output logic      [DATA_W-1:0] read_q
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DATA_W-1:0] entry_q [DEPTH];
   logic [DATA_W-1:0] masked  [DEPTH];
   logic [DEPTH-1:0]  hit;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_q;
      logic [DATA_W-1:0] right_q;

      // row ends take zeros; the first cell never uses its zero, the last shifts it in on an erase
      if (i == 0) begin : g_first
         assign left_q = '0;
      end else begin : g_left
         assign left_q = entry_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_q = '0;
      end else begin : g_right
         assign right_q = entry_q[i+1];
      end

      piel_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock   (clock),
         .cmd     (cmd),
         .left_q  (left_q),
         .right_q (right_q),
         .entry_q (entry_q[i]),
         .hit     (hit[i])
      );

      assign masked[i] = hit[i] ? entry_q[i] : '0;
   end

   // and-or read bus, at most one cell hits
   always_comb begin
      read_q = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_q = read_q | masked[i];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/positional_insert_erase_list_unit.sv
`default_nettype none
// channel | dir | tdata (low bit up)                        | tuser
// req     | in  | position[6:0] data_in[38:7] pad[39]       | op[1:0]
// rsp     | out | read_data[31:0] list_size[38:32]          | status[1:0]
//         |     | list_capacity[46:39] pad[47]              |
//
// one word per cycle while rsp_tready is high: a request is taken and its response
// registered at the same edge, so a word can follow every cycle; the row of cells moves
// all entries at once; the response is valid in the cycle after the request is accepted
// reset clears size and the response valid and sets capacity to one; entries are not cleared
// req_tready is low during reset and while a response waits and rsp_tready is low
module positional_insert_erase_list_unit import piel_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // position[6:0], data_in[38:7]
   input  wire logic [1:0]  req_tuser,  // op[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [47:0] rsp_tdata,  // read_data[31:0], list_size[38:32], list_capacity[46:39]
   output logic      [1:0]  rsp_tuser   // status[1:0]
);

`include "assert_macros.svh"

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CAP_W = $clog2(DEPTH) + 2;
   localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

   // request fields
   logic [POS_W-1:0]  position;
   logic [DATA_W-1:0] data_in;
   op_type            op;
   logic              accept;

   // list state
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CAP_W-1:0]  cap_ff;
   logic [CAP_W-1:0]  cap_in;

   // decode
   logic [PW-1:0]     pos_x;
   logic [PW-1:0]     cnt_x;
   logic              full;
   logic              ins_ok;
   logic              acc_ok;
   status_type        status;
   logic              is_get;
   cell_cmd_type      cmd;
   logic [DATA_W-1:0] read_q;

   // response register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [DATA_W-1:0] rsp_data_in;
   logic [SIZE_W-1:0] rsp_size_ff;
   logic [CAPO_W-1:0] rsp_cap_ff;
   status_type        rsp_status_ff;

   assign position = req_tdata[POS_W-1:0];
   assign data_in  = req_tdata[POS_W +: DATA_W];
   assign op       = op_type'(req_tuser);

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign pos_x = PW'(position);
   assign cnt_x = PW'(count_ff);
   assign full  = (count_ff == CNT_W'(DEPTH));

   // checks: full list wins over position for insert
   always_comb begin
      ins_ok = 1'b0;
      acc_ok = 1'b0;
      is_get = 1'b0;
      status = ST_DONE;
      unique case (op)
         OP_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else if (pos_x > cnt_x) begin
               status = ST_RANGE;
            end else begin
               ins_ok = 1'b1;
            end
         end
         OP_ERASE, OP_GET, OP_SET: begin
            if (pos_x >= cnt_x) begin
               status = ST_RANGE;
            end else begin
               acc_ok = 1'b1;
               is_get = (op == OP_GET);
            end
         end
         default: begin
            status = ST_DONE;
         end
      endcase
   end

   // row command, only live on an accepted word
   always_comb begin
      cmd.ins_shift = accept && ins_ok;
      cmd.era_shift = accept && acc_ok && (op == OP_ERASE);
      cmd.write     = accept && (ins_ok || (acc_ok && (op == OP_SET)));
      cmd.position  = position;
      cmd.data      = data_in;
   end

   piel_row #(
      .DEPTH (DEPTH)
   ) u_row (
      .clock  (clock),
      .cmd    (cmd),
      .read_q (read_q)
   );

   // size and capacity; capacity exceeds size, so one doubling per insert suffices
   always_comb begin
      count_in = count_ff;
      cap_in   = cap_ff;
      if (cmd.ins_shift) begin
         count_in = count_ff + CNT_W'(1);
         if (CAP_W'(count_ff) + CAP_W'(1) >= cap_ff) begin
            cap_in = {cap_ff[CAP_W-2:0], 1'b0};
         end
      end else if (cmd.era_shift) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign rsp_data_in  = is_get ? read_q : '0;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CAP_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload loads on accept only
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_size_ff   <= SIZE_W'(count_in);
         rsp_cap_ff    <= CAPO_W'(cap_in);
         rsp_status_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_cap_ff, rsp_size_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;

   `ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `ASSERT_IMPLY(a_cap_above, clock, reset, 1'b1, cap_ff > CAP_W'(count_ff))
   `ASSERT_IMPLY(a_cap_pow2, clock, reset, 1'b1, $onehot(cap_ff))
   `ASSERT_NEXT(a_ins_grow, clock, reset, cmd.ins_shift, count_ff == $past(count_ff) + CNT_W'(1))

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import piel_pkg::*;

   localparam int LIST_DEPTH = 64;
   localparam int ITEM_TOTAL = 1050;
   localparam int DIR_ROWS   = 25;

   // one response word as the block reports it
   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [SIZE_W-1:0] size;
      logic [CAPO_W-1:0] capacity;
      status_type        status;
   } rsp_word_type;

   // directed row; typed = 1 means the response is written out by hand
   typedef struct packed {
      op_type            op;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] data;
      logic              typed;
      rsp_word_type      rsp;
   } dir_row_type;

   typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_type;
   typedef enum int {RDY_OPEN, RDY_COIN, RDY_COMB, RDY_HOLD} ready_mode_type;

   localparam rsp_word_type NO_RSP = '{32'd0, 7'd0, 8'd0, ST_DONE};

   // empty-list misses and boundary positions are read off directly, the rest is predicted
   localparam dir_row_type DIR_TAB [DIR_ROWS] = '{
      '{OP_GET,    7'd0,   32'h0000_0000, 1'b1, '{32'h0000_0000, 7'd0, 8'd1, ST_RANGE}},
      '{OP_ERASE,  7'd0,   32'h0000_0000, 1'b1, '{32'h0000_0000, 7'd0, 8'd1, ST_RANGE}},
      '{OP_SET,    7'd0,   32'h7fff_ffff, 1'b1, '{32'h0000_0000, 7'd0, 8'd1, ST_RANGE}},
      '{OP_INSERT, 7'd1,   32'h0000_0001, 1'b1, '{32'h0000_0000, 7'd0, 8'd1, ST_RANGE}},
      '{OP_INSERT, 7'd127, 32'hffff_ffff, 1'b1, '{32'h0000_0000, 7'd0, 8'd1, ST_RANGE}},
      '{OP_INSERT, 7'd0,   32'h8000_0000, 1'b1, '{32'h0000_0000, 7'd1, 8'd2, ST_DONE}},
      '{OP_GET,    7'd0,   32'h0000_0000, 1'b1, '{32'h8000_0000, 7'd1, 8'd2, ST_DONE}},
      '{OP_INSERT, 7'd1,   32'h7fff_ffff, 1'b1, '{32'h0000_0000, 7'd2, 8'd4, ST_DONE}},
      '{OP_GET,    7'd1,   32'h0000_0000, 1'b1, '{32'h7fff_ffff, 7'd2, 8'd4, ST_DONE}},
      '{OP_GET,    7'd2,   32'h0000_0000, 1'b1, '{32'h0000_0000, 7'd2, 8'd4, ST_RANGE}},
      '{OP_SET,    7'd127, 32'h0000_0000, 1'b1, '{32'h0000_0000, 7'd2, 8'd4, ST_RANGE}},
      '{OP_INSERT, 7'd1,   32'h1234_5678, 1'b0, NO_RSP},
      '{OP_INSERT, 7'd0,   32'h0000_0000, 1'b0, NO_RSP},
      '{OP_GET,    7'd0,   32'h0000_0000, 1'b0, NO_RSP},
      '{OP_GET,    7'd2,   32'h0000_0000, 1'b0, NO_RSP},
      '{OP_GET,    7'd3,   32'h0000_0000, 1'b0, NO_RSP},
      '{OP_SET,    7'd2,   32'hffff_ffff, 1'b0, NO_RSP},
      '{OP_GET,    7'd2,   32'h0000_0000, 1'b0, NO_RSP},
      '{OP_ERASE,  7'd4,   32'h0000_0000, 1'b0, NO_RSP},
      '{OP_ERASE,  7'd1,   32'h0000_0000, 1'b0, NO_RSP},
      '{OP_ERASE,  7'd0,   32'h0000_0000, 1'b0, NO_RSP},
      '{OP_GET,    7'd0,   32'h0000_0000, 1'b0, NO_RSP},
      '{OP_ERASE,  7'd1,   32'h0000_0000, 1'b0, NO_RSP},
      '{OP_ERASE,  7'd0,   32'h0000_0000, 1'b0, NO_RSP},
      '{OP_GET,    7'd0,   32'h0000_0000, 1'b0, NO_RSP}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;  // position[6:0], data_in[38:7]
   logic [1:0]  req_tuser  = '0;  // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // read_data[31:0], list_size[38:32], list_capacity[46:39]
   logic [1:0]  rsp_tuser;        // status[1:0]

   // shadow copy of the list
   logic [DATA_W-1:0] list_words [LIST_DEPTH];
   int unsigned       list_count = 0;
   int unsigned       list_cap   = 1;

   rsp_word_type pending_rsp [$];
   int           mismatch_count = 0;
   int           burst_left     = 0;

   positional_insert_erase_list_unit #(.DEPTH(LIST_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("positional_insert_erase_list_unit test failed");
      $finish;
   end

   // apply one operation to the shadow list and form the response word it gives
   task automatic apply_to_list(input op_type op, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] value, output rsp_word_type r);
      int unsigned       p;
      int unsigned       i;
      logic [DATA_W-1:0] rd;
      status_type        st;
      p  = pos;
      rd = '0;
      st = ST_DONE;
      if (op == OP_INSERT) begin
         // full check wins over the position check
         if (list_count >= LIST_DEPTH) begin
            st = ST_FULL;
         end else if (p > list_count) begin
            st = ST_RANGE;
         end else begin
            while (list_count + 1 >= list_cap && list_cap < 32'h8000_0000)
               list_cap = list_cap * 2;
            for (i = list_count; i > p; i--)
               list_words[i] = list_words[i-1];
            list_words[p] = value;
            list_count++;
         end
      end else if (p >= list_count) begin
         st = ST_RANGE;
      end else if (op == OP_ERASE) begin
         for (i = p; i + 1 < list_count; i++)
            list_words[i] = list_words[i+1];
         list_count--;
      end else if (op == OP_GET) begin
         rd = list_words[p];
      end else begin
         list_words[p] = value;
      end
      r.read_data = rd;
      r.size      = list_count[SIZE_W-1:0];
      r.capacity  = list_cap[CAPO_W-1:0];
      r.status    = st;
   endtask

   // offer one request word in bursts with gaps; predict it once it is taken
   task automatic send_word(input op_type op, input logic [POS_W-1:0] pos,
                            input logic [DATA_W-1:0] value, input logic typed,
                            input rsp_word_type typed_rsp);
      int           gap;
      rsp_word_type r;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, value, pos};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      apply_to_list(op, pos, value, r);
      pending_rsp.push_back(typed ? typed_rsp : r);
   endtask

   // stop sending until every response word has come back
   task automatic hold_until_answered();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
      burst_left = 0;
   endtask

   function automatic op_type pick_op(phase_type ph);
      int k;
      k = $urandom_range(0, 99);
      case (ph)
         PH_FILL: begin
            if (k < 70)      return OP_INSERT;
            else if (k < 80) return OP_ERASE;
            else if (k < 90) return OP_GET;
            else             return OP_SET;
         end
         PH_DRAIN: begin
            if (k < 15)      return OP_INSERT;
            else if (k < 70) return OP_ERASE;
            else if (k < 85) return OP_GET;
            else             return OP_SET;
         end
         default: return op_type'($urandom_range(0, 3));
      endcase
   endfunction

   // mostly legal positions, some right at the end, some anywhere in the field
   function automatic logic [POS_W-1:0] pick_position(op_type op);
      int unsigned lim;
      int          k;
      if (op == OP_INSERT) lim = list_count;
      else                 lim = (list_count == 0) ? 0 : list_count - 1;
      k = $urandom_range(0, 9);
      if (k < 7)       return POS_W'($urandom_range(0, lim));
      else if (k == 7) return POS_W'(list_count);
      else             return POS_W'($urandom_range(0, 127));
   endfunction

   function automatic logic [DATA_W-1:0] pick_data();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // receiver backpressure, its own pattern independent of the sender
   ready_mode_type rdy_mode = RDY_OPEN;
   int             rdy_left = 0;
   int             rdy_tick = 0;

   always @(posedge clock) begin
      if (rdy_left == 0) begin
         rdy_mode = ready_mode_type'($urandom_range(0, 3));
         rdy_left = $urandom_range(4, 40);
         rdy_tick = 0;
      end
      rdy_left--;
      rdy_tick++;
      case (rdy_mode)
         RDY_OPEN: rsp_tready <= 1'b1;
         RDY_COIN: rsp_tready <= 1'($urandom_range(0, 1));
         RDY_COMB: rsp_tready <= (rdy_tick % 4 != 0);
         default:  rsp_tready <= (rdy_left < 2);  // long stall, short release
      endcase
   end

   // response checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $error("response word with nothing expected");
            mismatch_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tdata[31:0] !== want.read_data) begin
               $error("read_data expected %h got %h", want.read_data, rsp_tdata[31:0]);
               mismatch_count++;
            end
            if (rsp_tdata[38:32] !== want.size) begin
               $error("list_size expected %0d got %0d", want.size, rsp_tdata[38:32]);
               mismatch_count++;
            end
            if (rsp_tdata[46:39] !== want.capacity) begin
               $error("list_capacity expected %0d got %0d", want.capacity, rsp_tdata[46:39]);
               mismatch_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int        sent;
      int        phase_len;
      logic      first_phase;
      phase_type ph;
      op_type    op;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < DIR_ROWS; n++)
         send_word(DIR_TAB[n].op, DIR_TAB[n].position, DIR_TAB[n].data,
                   DIR_TAB[n].typed, DIR_TAB[n].rsp);
      hold_until_answered();

      // random phases; the first one is long and insert heavy so the list fills up
      sent        = 0;
      first_phase = 1'b1;
      while (sent < ITEM_TOTAL - DIR_ROWS) begin
         if (first_phase) begin
            ph        = PH_FILL;
            phase_len = 200;
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7: ph = PH_FILL;
               8, 9, 10, 11, 12:       ph = PH_DRAIN;
               default:                ph = PH_MIXED;
            endcase
            phase_len = $urandom_range(40, 140);
         end
         // last phase stops at the item total
         if (phase_len > ITEM_TOTAL - DIR_ROWS - sent)
            phase_len = ITEM_TOTAL - DIR_ROWS - sent;
         repeat (phase_len) begin
            op = pick_op(ph);
            send_word(op, pick_position(op), pick_data(), 1'b0, NO_RSP);
            sent++;
         end
         if (first_phase || $urandom_range(0, 3) == 0)
            hold_until_answered();
         first_phase = 1'b0;
      end

      hold_until_answered();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("positional_insert_erase_list_unit test passed");
      else
         $display("positional_insert_erase_list_unit test failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/piel_pkg.sv
rtl/piel_cell.sv
rtl/piel_row.sv
rtl/positional_insert_erase_list_unit.sv
tb/tb_top.sv
